/* src/vae_pkg.sv */
// Shared types, codes and constants of the vibration alert envelope block.
`timescale 1ns / 1ps
`default_nettype none

package vae_pkg;

  // Field widths
  localparam int unsigned DutyW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned StepW  = 7;
  localparam int unsigned PowerW = 7;
  localparam int unsigned ShapeW = 2;
  localparam int unsigned DataW  = 64;
  localparam int unsigned AddrW  = 6;

  // Envelope constants
  localparam logic [StepW-1:0] StepLast = 7'd100;
  localparam logic [StepW-1:0] TriMid   = 7'd50;
  localparam logic [DutyW-1:0] FullShape = 8'd100;
  localparam logic [4:0]       SineMid  = 5'd10;
  localparam logic [4:0]       SineSpan = 5'd20;

  // Divide by 100: x * 83887 >> 23, exact for x below 2^16
  localparam logic [16:0] Recip100 = 17'd83887;
  localparam int unsigned Shift100 = 23;
  // Divide by 5: x * 205 >> 10, exact for x up to 100
  localparam logic [7:0]  Recip5   = 8'd205;
  localparam int unsigned Shift5   = 10;

  // Register map, one 64-bit register every 8 bytes
  typedef enum logic [2:0] {
    REG_DUTY_FLOOR   = 3'd0,
    REG_DUTY_CEILING = 3'd1,
    REG_WAVE_SHAPE   = 3'd2,
    REG_POWER_PCT    = 3'd3,
    REG_ON_TIME      = 3'd4,
    REG_OFF_TIME     = 3'd5,
    REG_SINE_LO      = 3'd6,
    REG_SINE_HI      = 3'd7
  } reg_idx_e;

  typedef enum logic [ShapeW-1:0] {
    SHAPE_SQUARE   = 2'd0,
    SHAPE_HALFSINE = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SAWTOOTH = 2'd3
  } wave_shape_e;

  // Source of the duty of one result word
  typedef enum logic [1:0] {
    DUTY_ZERO = 2'd0,
    DUTY_HOLD = 2'd1,
    DUTY_ON   = 2'd2
  } duty_kind_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MUL1 = 5'b00100,
    S_MUL2 = 5'b01000,
    S_MUL3 = 5'b10000
  } ctrl_state_e;

  typedef struct packed {
    logic [DutyW-1:0]  duty_floor;
    logic [DutyW-1:0]  duty_ceiling;
    logic [ShapeW-1:0] wave_shape;
    logic [PowerW-1:0] power_pct;
    logic [7:0]        on_time;
    logic [7:0]        off_time;
    logic [63:0]       sine_table_lo;
    logic [23:0]       sine_table_hi;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mul1;
    logic mul2;
    logic fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* src/vae_if.sv */
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps
`default_nettype none

interface vae_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] cycle_count;
  logic       motor_is_lra;

  modport source (output valid, cmd, cycle_count, motor_is_lra, input ready);
  modport sink   (input valid, cmd, cycle_count, motor_is_lra, output ready);
endinterface

interface vae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       active;
  logic       accepted;
  logic       finished;

  modport source (output valid, duty, active, accepted, finished, input ready);
  modport sink   (input valid, duty, active, accepted, finished, output ready);
endinterface

`default_nettype wire

/* src/vae_regs.sv */
// APB-style configuration register file.
`timescale 1ns / 1ps
`default_nettype none

module vae_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [vae_pkg::AddrW-1:0]  paddr,
  input  wire logic [vae_pkg::DataW-1:0]  pwdata,
  output logic      [vae_pkg::DataW-1:0]  prdata,
  output logic                            pready,
  output vae_pkg::cfg_t                   cfg_o
);

  vae_pkg::cfg_t    cfg_q, cfg_d;
  vae_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = vae_pkg::reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        vae_pkg::REG_DUTY_FLOOR:   cfg_d.duty_floor    = pwdata[7:0];
        vae_pkg::REG_DUTY_CEILING: cfg_d.duty_ceiling  = pwdata[7:0];
        vae_pkg::REG_WAVE_SHAPE:   cfg_d.wave_shape    = pwdata[1:0];
        vae_pkg::REG_POWER_PCT:    cfg_d.power_pct     = pwdata[6:0];
        vae_pkg::REG_ON_TIME:      cfg_d.on_time       = pwdata[7:0];
        vae_pkg::REG_OFF_TIME:     cfg_d.off_time      = pwdata[7:0];
        vae_pkg::REG_SINE_LO:      cfg_d.sine_table_lo = pwdata;
        vae_pkg::REG_SINE_HI:      cfg_d.sine_table_hi = pwdata[23:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_floor    <= 8'd0;
      cfg_q.duty_ceiling  <= 8'd255;
      cfg_q.wave_shape    <= 2'd0;
      cfg_q.power_pct     <= 7'd100;
      cfg_q.on_time       <= 8'd1;
      cfg_q.off_time      <= 8'd0;
      cfg_q.sine_table_lo <= 64'd0;
      cfg_q.sine_table_hi <= 24'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      vae_pkg::REG_DUTY_FLOOR:   prdata = {56'd0, cfg_q.duty_floor};
      vae_pkg::REG_DUTY_CEILING: prdata = {56'd0, cfg_q.duty_ceiling};
      vae_pkg::REG_WAVE_SHAPE:   prdata = {62'd0, cfg_q.wave_shape};
      vae_pkg::REG_POWER_PCT:    prdata = {57'd0, cfg_q.power_pct};
      vae_pkg::REG_ON_TIME:      prdata = {56'd0, cfg_q.on_time};
      vae_pkg::REG_OFF_TIME:     prdata = {56'd0, cfg_q.off_time};
      vae_pkg::REG_SINE_LO:      prdata = cfg_q.sine_table_lo;
      vae_pkg::REG_SINE_HI:      prdata = {40'd0, cfg_q.sine_table_hi};
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* src/vae_ctrl.sv */
// Sequencer that steps one request word through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module vae_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  output logic                item_ready_o,
  input  vae_pkg::ctrl_sts_t  sts_i,
  output vae_pkg::ctrl_cmd_t  cmd_o
);

  vae_pkg::ctrl_state_e state_q, state_d;

  assign item_ready_o = (state_q == vae_pkg::S_IDLE);

  // Issue the command of the current step
  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == vae_pkg::S_IDLE) && item_valid_i;
    cmd_o.exec = (state_q == vae_pkg::S_EXEC);
    cmd_o.mul1 = (state_q == vae_pkg::S_MUL1);
    cmd_o.mul2 = (state_q == vae_pkg::S_MUL2);
    cmd_o.fin  = (state_q == vae_pkg::S_MUL3) && !sts_i.out_blocked;
  end

  // Advance through the steps; wait at the last one while the result slot is full
  always_comb begin
    state_d = state_q;
    case (state_q)
      vae_pkg::S_IDLE: if (item_valid_i) state_d = vae_pkg::S_EXEC;
      vae_pkg::S_EXEC: state_d = vae_pkg::S_MUL1;
      vae_pkg::S_MUL1: state_d = vae_pkg::S_MUL2;
      vae_pkg::S_MUL2: state_d = vae_pkg::S_MUL3;
      vae_pkg::S_MUL3: if (!sts_i.out_blocked) state_d = vae_pkg::S_IDLE;
      default:         state_d = vae_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vae_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* src/vae_dp.sv */
// Datapath: alert state, envelope shape, duty arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none

module vae_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  vae_pkg::cfg_t            cfg_i,
  input  vae_pkg::ctrl_cmd_t       cmd_i,
  output vae_pkg::ctrl_sts_t       sts_o,
  input  wire logic                item_cmd_i,
  input  wire logic [7:0]          item_cycle_count_i,
  input  wire logic                item_motor_is_lra_i,
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output logic [7:0]               res_duty_o,
  output logic                     res_active_o,
  output logic                     res_accepted_o,
  output logic                     res_finished_o
);

  // Captured request word
  logic       cmd_q;
  logic [7:0] cnt_q;
  logic       lra_q;

  // Alert state
  logic       busy_q, busy_d;
  logic       phase_on_q, phase_on_d;
  logic [7:0] cycles_q, cycles_d;
  logic [7:0] ms_q, ms_d;
  logic [6:0] step_q, step_d;
  logic [7:0] last_duty_q;

  // Pipeline registers
  vae_pkg::duty_kind_e kind_q, kind_d;
  logic [6:0]  t_q, t_d;
  logic        act_q, acc_q, fin_q;
  logic        acc_d, fin_d;
  logic [14:0] prod_a_q;
  logic [7:0]  shape_q;
  logic [8:0]  q1_q;
  logic [15:0] prod_b_q;

  // Result register
  logic       out_valid_q;
  logic [7:0] out_duty_q;
  logic       out_active_q, out_accepted_q, out_finished_q;

  // Combinational helpers
  logic [7:0]  len;
  logic [7:0]  ms_inc;
  logic [6:0]  step_inc;
  logic [7:0]  range;
  logic [14:0] sine_mul;
  logic [4:0]  sine_d;
  logic [3:0]  sine_idx;
  logic [127:0] sine_tbl;
  logic [5:0]  tri_d;
  logic [7:0]  shape_d;
  logic [31:0] q1_full;
  logic [16:0] prod_b_full;
  logic [32:0] q2_full;
  logic [7:0]  on_duty;
  logic [7:0]  duty_sel;

  assign sts_o.out_blocked = out_valid_q && !res_ready_i;

  // Capture the request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= item_cmd_i;
      cnt_q <= item_cycle_count_i;
      lra_q <= item_motor_is_lra_i;
    end
  end

  // Update the alert state for one word
  always_comb begin
    busy_d     = busy_q;
    phase_on_d = phase_on_q;
    cycles_d   = cycles_q;
    ms_d       = ms_q;
    step_d     = step_q;
    kind_d     = vae_pkg::DUTY_ZERO;
    t_d        = step_q;
    acc_d      = 1'b0;
    fin_d      = 1'b0;
    len        = phase_on_q ? cfg_i.on_time : cfg_i.off_time;
    if (len == 8'd0) len = 8'd1;
    ms_inc     = ms_q + 8'd1;
    step_inc   = (step_q < vae_pkg::StepLast) ? step_q + 7'd1 : step_q;
    if (cmd_q) begin
      if (busy_q || lra_q) begin
        kind_d = busy_q ? vae_pkg::DUTY_HOLD : vae_pkg::DUTY_ZERO;
      end else begin
        acc_d      = 1'b1;
        phase_on_d = 1'b1;
        ms_d       = 8'd0;
        step_d     = 7'd0;
        cycles_d   = cnt_q;
        busy_d     = (cnt_q != 8'd0);
        fin_d      = (cnt_q == 8'd0);
      end
    end else if (busy_q) begin
      ms_d   = ms_inc;
      step_d = step_q;
      if (ms_inc >= len) begin
        ms_d   = 8'd0;
        step_d = step_inc;
      end
      t_d = step_d;
      if (phase_on_q) begin
        kind_d = (cfg_i.power_pct != '0) ? vae_pkg::DUTY_ON : vae_pkg::DUTY_ZERO;
        if (step_d >= vae_pkg::StepLast) begin
          if (cfg_i.off_time != 8'd0) begin
            phase_on_d = 1'b0;
            kind_d     = vae_pkg::DUTY_ZERO;
          end else begin
            cycles_d = cycles_q - 8'd1;
          end
          ms_d   = 8'd0;
          step_d = 7'd0;
        end
      end else if (step_d >= vae_pkg::StepLast) begin
        phase_on_d = 1'b1;
        ms_d       = 8'd0;
        step_d     = 7'd0;
        cycles_d   = cycles_q - 8'd1;
      end
      // Drop out on the last cycle
      if (cycles_d == 8'd0) begin
        busy_d     = 1'b0;
        fin_d      = 1'b1;
        kind_d     = vae_pkg::DUTY_ZERO;
        phase_on_d = 1'b1;
        ms_d       = 8'd0;
        step_d     = 7'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      phase_on_q <= 1'b1;
      cycles_q   <= 8'd0;
      ms_q       <= 8'd0;
      step_q     <= 7'd0;
    end else if (cmd_i.exec) begin
      busy_q     <= busy_d;
      phase_on_q <= phase_on_d;
      cycles_q   <= cycles_d;
      ms_q       <= ms_d;
      step_q     <= step_d;
    end
  end

  // Scaled power, power times range
  assign range = cfg_i.duty_ceiling - cfg_i.duty_floor;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      kind_q   <= kind_d;
      t_q      <= t_d;
      act_q    <= busy_d;
      acc_q    <= acc_d;
      fin_q    <= fin_d;
      prod_a_q <= cfg_i.power_pct * range;
    end
  end

  // Envelope shape at step t
  assign sine_tbl = {40'd0, cfg_i.sine_table_hi, cfg_i.sine_table_lo};
  assign sine_mul = t_q * vae_pkg::Recip5;
  assign sine_d   = sine_mul[14:vae_pkg::Shift5];
  assign sine_idx = (sine_d >= vae_pkg::SineMid) ? 4'(vae_pkg::SineSpan - sine_d)
                                                 : sine_d[3:0];
  assign tri_d    = (t_q >= vae_pkg::TriMid) ? 6'(t_q - vae_pkg::TriMid)
                                             : 6'(vae_pkg::TriMid - t_q);

  always_comb begin
    case (vae_pkg::wave_shape_e'(cfg_i.wave_shape))
      vae_pkg::SHAPE_HALFSINE: shape_d = sine_tbl[sine_idx*8 +: 8];
      vae_pkg::SHAPE_TRIANGLE: shape_d = vae_pkg::FullShape - {1'b0, tri_d, 1'b0};
      vae_pkg::SHAPE_SAWTOOTH: shape_d = {1'b0, t_q};
      default:                 shape_d = vae_pkg::FullShape;
    endcase
  end

  // First divide by 100, shape lookup alongside
  assign q1_full = prod_a_q * vae_pkg::Recip100;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      q1_q    <= q1_full[31:vae_pkg::Shift100];
      shape_q <= shape_d;
    end
  end

  // Scale by shape, keep sixteen bits
  assign prod_b_full = q1_q * shape_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      prod_b_q <= prod_b_full[15:0];
    end
  end

  // Second divide by 100 and offset
  assign q2_full = prod_b_q * vae_pkg::Recip100;
  assign on_duty = q2_full[30:vae_pkg::Shift100] + cfg_i.duty_floor;

  always_comb begin
    case (kind_q)
      vae_pkg::DUTY_HOLD: duty_sel = last_duty_q;
      vae_pkg::DUTY_ON:   duty_sel = on_duty;
      default:            duty_sel = 8'd0;
    endcase
  end

  // Remember the duty being driven
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_duty_q <= 8'd0;
    end else if (cmd_i.fin) begin
      last_duty_q <= duty_sel;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_duty_q     <= duty_sel;
      out_active_q   <= act_q;
      out_accepted_q <= acc_q;
      out_finished_q <= fin_q;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign res_duty_o     = out_duty_q;
  assign res_active_o   = out_active_q;
  assign res_accepted_o = out_accepted_q;
  assign res_finished_o = out_finished_q;

endmodule

`default_nettype wire

/* src/vibration_alert_envelope_pwm.sv */
// Top level of the vibration alert envelope PWM generator.
//
// Each request word is a 1 ms tick or a start request; each gives one result
// word with the PWM duty for that millisecond and the alert flags. An accepted
// word first updates the alert counters, then runs the sequenced duty chain
// (two multiply-by-reciprocal divides by 100 around the shape multiply, each
// with its own register) into the result register; the final step waits
// while the result slot is full. A new word is accepted as soon as the previous
// one has reached the result register, never while one is in the datapath.
// Configuration writes complete in the APB access cycle and are meant to be
// made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module vibration_alert_envelope_pwm (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  vae_in_if.sink                         item_i,
  vae_out_if.source                      result_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [vae_pkg::AddrW-1:0] paddr,
  input  wire logic [vae_pkg::DataW-1:0] pwdata,
  output logic      [vae_pkg::DataW-1:0] prdata,
  output logic                           pready
);

  vae_pkg::cfg_t      cfg;
  vae_pkg::ctrl_cmd_t cmd;
  vae_pkg::ctrl_sts_t sts;

  vae_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vae_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  vae_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .item_cmd_i          (item_i.cmd),
    .item_cycle_count_i  (item_i.cycle_count),
    .item_motor_is_lra_i (item_i.motor_is_lra),
    .res_valid_o         (result_o.valid),
    .res_ready_i         (result_o.ready),
    .res_duty_o          (result_o.duty),
    .res_active_o        (result_o.active),
    .res_accepted_o      (result_o.accepted),
    .res_finished_o      (result_o.finished)
  );

  // No request is taken while a word is still in the datapath
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.ready |-> !(cmd.exec || cmd.mul1 || cmd.mul2 || cmd.fin))
    else $error("request accepted while a word is in flight");

  // An accepted request starts the counter update next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> cmd.exec)
    else $error("accepted word did not reach the update step");

  // A result is never written over one that waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |-> !(result_o.valid && !result_o.ready))
    else $error("result register overwritten");

  // A finished alert is no longer running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.finished) |-> !result_o.active)
    else $error("finished word still shows the alert active");

endmodule

`default_nettype wire
